FILE: sv/cobc_pkg.sv
// Shared types, constants and arithmetic helpers for the circle/oriented-box collision pipe.
package cobc_pkg;

    localparam int COORD_BITS     = 16;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int ANGLE_BITS     = 16;
    localparam int OCT_BITS       = ANGLE_BITS - 2;

    // octant angle in radians, Q30
    localparam int PH_BITS   = 30;
    localparam int STEP_BITS = 17;
    localparam logic [STEP_BITS-1:0] ANGLE_STEP = STEP_BITS'(102944);
    localparam int STEP_PROD_W = OCT_BITS + STEP_BITS;
    localparam logic [PH_BITS:0] ONE_Q = (PH_BITS+1)'(1) << PH_BITS;

    // exact floor division of a PH_BITS value by a constant: (v * m) >> sh
    localparam int RECIP_W = PH_BITS + 1;
    localparam int SH_6     = PH_BITS + 3;
    localparam int SH_24    = PH_BITS + 5;
    localparam int SH_120   = PH_BITS + 7;
    localparam int SH_720   = PH_BITS + 10;
    localparam int SH_5040  = PH_BITS + 13;
    localparam int SH_40320 = PH_BITS + 16;
    localparam logic [RECIP_W-1:0] RECIP_6     = RECIP_W'((64'd1 << SH_6) / 64'd6 + 64'd1);
    localparam logic [RECIP_W-1:0] RECIP_24    = RECIP_W'((64'd1 << SH_24) / 64'd24 + 64'd1);
    localparam logic [RECIP_W-1:0] RECIP_120   = RECIP_W'((64'd1 << SH_120) / 64'd120 + 64'd1);
    localparam logic [RECIP_W-1:0] RECIP_720   = RECIP_W'((64'd1 << SH_720) / 64'd720 + 64'd1);
    localparam logic [RECIP_W-1:0] RECIP_5040  =
        RECIP_W'((64'd1 << SH_5040) / 64'd5040 + 64'd1);
    localparam logic [RECIP_W-1:0] RECIP_40320 =
        RECIP_W'((64'd1 << SH_40320) / 64'd40320 + 64'd1);

    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = DIFF_W + TRIG_W;
    localparam int ROT_W  = PROD_W + 1;
    localparam int RND_SH = TRIG_FRAC_BITS - 1;
    localparam int RX_W   = ROT_W - RND_SH;
    localparam int EX_W   = RX_W;
    localparam int RAD2_W = COORD_BITS;
    localparam int SQ_W   = 2 * RAD2_W;

    localparam int PIPE_DEPTH = 12;
    localparam int INFLIGHT_W = $clog2(PIPE_DEPTH + 1);

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic                         occupied;
        logic signed [COORD_BITS-1:0] box_x;
        logic signed [COORD_BITS-1:0] box_y;
        logic [COORD_BITS-2:0]        box_width;
        logic [COORD_BITS-2:0]        box_height;
        logic [ANGLE_BITS-1:0]        box_angle;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [COORD_BITS-2:0]        radius;
    } item_t;

    typedef struct packed {
        logic hit;
    } result_t;

    // geometry that rides alongside the trig pipe
    typedef struct packed {
        logic                     occupied;
        quad_t                    quad;
        logic                     swap;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [COORD_BITS-2:0]    hw;
        logic [COORD_BITS-2:0]    hh;
        logic [RAD2_W-1:0]        rad2;
    } geo_t;

    function automatic logic [PH_BITS-1:0] qmul(input logic [PH_BITS-1:0] a,
                                                input logic [PH_BITS-1:0] b);
        logic [2*PH_BITS-1:0] p;
        p = {{PH_BITS{1'b0}}, a} * {{PH_BITS{1'b0}}, b};
        return p[2*PH_BITS-1:PH_BITS];
    endfunction

    function automatic logic [PH_BITS-1:0] recip_div(input logic [PH_BITS-1:0] v,
                                                     input logic [RECIP_W-1:0] m,
                                                     input int sh);
        logic [PH_BITS+RECIP_W-1:0] p;
        p = {{RECIP_W{1'b0}}, v} * {{PH_BITS{1'b0}}, m};
        return PH_BITS'(p >> sh);
    endfunction

    // round half up from Q30 to TRIG_FRAC_BITS
    function automatic logic [TRIG_FRAC_BITS:0] round_trig(input logic [PH_BITS:0] v);
        logic [PH_BITS:0] t;
        t = v + ((PH_BITS+1)'(1) << (PH_BITS - 1 - TRIG_FRAC_BITS));
        return t[PH_BITS:PH_BITS-TRIG_FRAC_BITS];
    endfunction

endpackage

FILE: sv/cobc_item_if.sv
// Valid/ready channel carrying one input word.
interface cobc_item_if import cobc_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/cobc_result_if.sv
// Valid/ready channel carrying one result word.
interface cobc_result_if import cobc_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/circle_oriented_box_collision.sv
// The result word is registered in the last of 12 register stages (stage 0 to stage 11).
// Throughput: one word per cycle while the output word is taken; sin/cos Taylor terms, rotation and squares are
// spread one multiplier deep per stage.
// When the output word is not taken the whole pipe holds; item.ready drops then.
// Reset (rst_n low, async) clears the stage valid bits only; no clearing pass.
module circle_oriented_box_collision import cobc_pkg::*; (
    input logic           clk,
    input logic           rst_n,
    cobc_item_if.sink     item,
    cobc_result_if.source result
);

    localparam int LAST = PIPE_DEPTH - 1;
    localparam logic [OCT_BITS-1:0] OCT_HALF = OCT_BITS'(1) << (OCT_BITS - 1);
    localparam logic [OCT_BITS:0]   OCT_FULL = (OCT_BITS+1)'(1) << OCT_BITS;
    localparam logic signed [ROT_W-1:0] RND_HALF = ROT_W'(1) << (TRIG_FRAC_BITS - 2);

    logic en;
    logic [PIPE_DEPTH-1:0] v_reg;
    geo_t geo_reg [0:LAST-1];

    // trig pipe
    logic [PH_BITS-1:0] x_reg  [0:4];
    logic [PH_BITS-1:0] x2_reg [1:4];
    logic [PH_BITS-1:0] x3_reg, x5_reg, x6_reg, x8_reg, x7_reg;
    logic [PH_BITS-1:0] x4_reg [2:3];
    logic [PH_BITS-1:0] q3_reg [3:4];
    logic [PH_BITS-1:0] q4_reg, q5_reg, q6_reg, q8_reg, q7_reg;
    logic [PH_BITS:0]   sp_reg, cv_reg;
    logic signed [TRIG_W-1:0] s_reg, c_reg;

    // rotate / clamp / compare
    logic signed [PROD_W-1:0] p_cdx_reg, p_sdy_reg, p_cdy_reg, p_sdx_reg;
    logic signed [RX_W-1:0]   rx_reg, ry_reg;
    logic [EX_W-1:0]          ex_reg, ey_reg;
    logic                     near_reg;
    logic [SQ_W-1:0]          e2x_reg, e2y_reg, r2_reg;
    logic                     hit_reg;

    // stage 0 inputs
    logic [OCT_BITS-1:0] r_raw, r_oct;
    geo_t                geo_next;
    logic [PH_BITS-1:0]  x_next;

    // stage 6 / 8 / 9 helpers
    logic [PH_BITS:0]          sv_next;
    logic [TRIG_FRAC_BITS:0]   s_oct, c_oct;
    logic signed [TRIG_W-1:0]  s0, c0, s_next, c_next;
    logic signed [ROT_W-1:0]   rx_sum, ry_sum;
    logic [EX_W-1:0]           ex_next, ey_next;

    function automatic logic [EX_W-1:0] clamp_excess(input logic signed [RX_W-1:0] v,
                                                     input logic [COORD_BITS-2:0] half);
        logic signed [RX_W:0] vw;
        logic signed [RX_W:0] hw;
        logic signed [RX_W:0] e;
        vw = (RX_W+1)'(v);
        hw = (RX_W+1)'(signed'({1'b0, half}));
        priority if (vw > hw)
            e = vw - hw;
        else if (vw < -hw)
            e = -hw - vw;
        else
            e = '0;
        return EX_W'(e);
    endfunction

    assign en           = !v_reg[LAST] || result.ready;
    assign item.ready   = en;
    assign result.valid = v_reg[LAST];
    assign result.data  = '{hit: hit_reg};

    always_comb
    begin
        r_raw = item.data.box_angle[OCT_BITS-1:0];
        geo_next.occupied = item.data.occupied;
        geo_next.quad     = quad_t'(item.data.box_angle[ANGLE_BITS-1 -: 2]);
        geo_next.swap     = r_raw > OCT_HALF;
        geo_next.dx       = DIFF_W'(item.data.point_x) - DIFF_W'(item.data.box_x);
        geo_next.dy       = DIFF_W'(item.data.point_y) - DIFF_W'(item.data.box_y);
        geo_next.hw       = item.data.box_width;
        geo_next.hh       = item.data.box_height;
        geo_next.rad2     = {item.data.radius, 1'b0};
        r_oct  = geo_next.swap ? OCT_BITS'(OCT_FULL - {1'b0, r_raw}) : r_raw;
        x_next = PH_BITS'(STEP_PROD_W'(r_oct) * STEP_PROD_W'(ANGLE_STEP));
    end

    // stage 6: finish sin, round, fold octant and quadrant
    always_comb
    begin
        sv_next = sp_reg - {1'b0, q7_reg};
        s_oct   = round_trig(sv_next);
        c_oct   = round_trig(cv_reg);
        if (geo_reg[5].swap)
        begin
            s0 = signed'({1'b0, c_oct});
            c0 = signed'({1'b0, s_oct});
        end
        else
        begin
            s0 = signed'({1'b0, s_oct});
            c0 = signed'({1'b0, c_oct});
        end
        unique case (geo_reg[5].quad)
            QUAD_0:
            begin
                s_next = s0;
                c_next = c0;
            end
            QUAD_1:
            begin
                s_next = c0;
                c_next = -s0;
            end
            QUAD_2:
            begin
                s_next = -s0;
                c_next = -c0;
            end
            QUAD_3:
            begin
                s_next = -c0;
                c_next = s0;
            end
            default:
            begin
                s_next = s0;
                c_next = c0;
            end
        endcase
    end

    always_comb
    begin
        rx_sum  = ROT_W'(p_cdx_reg) + ROT_W'(p_sdy_reg) + RND_HALF;
        ry_sum  = ROT_W'(p_cdy_reg) - ROT_W'(p_sdx_reg) + RND_HALF;
        ex_next = clamp_excess(rx_reg, geo_reg[8].hw);
        ey_next = clamp_excess(ry_reg, geo_reg[8].hh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[LAST-1:0], item.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg[0] <= geo_next;
            for (int i = 1; i < LAST; i++)
                geo_reg[i] <= geo_reg[i-1];

            // stage 0
            x_reg[0] <= x_next;
            // stage 1
            x_reg[1]  <= x_reg[0];
            x2_reg[1] <= qmul(x_reg[0], x_reg[0]);
            // stage 2
            x_reg[2]  <= x_reg[1];
            x2_reg[2] <= x2_reg[1];
            x3_reg    <= qmul(x2_reg[1], x_reg[1]);
            x4_reg[2] <= qmul(x2_reg[1], x2_reg[1]);
            // stage 3
            x_reg[3]  <= x_reg[2];
            x2_reg[3] <= x2_reg[2];
            x4_reg[3] <= x4_reg[2];
            q3_reg[3] <= recip_div(x3_reg, RECIP_6, SH_6);
            x5_reg    <= qmul(x4_reg[2], x_reg[2]);
            x6_reg    <= qmul(x4_reg[2], x2_reg[2]);
            x8_reg    <= qmul(x4_reg[2], x4_reg[2]);
            // stage 4
            x_reg[4]  <= x_reg[3];
            x2_reg[4] <= x2_reg[3];
            q3_reg[4] <= q3_reg[3];
            q4_reg    <= recip_div(x4_reg[3], RECIP_24, SH_24);
            q5_reg    <= recip_div(x5_reg, RECIP_120, SH_120);
            q6_reg    <= recip_div(x6_reg, RECIP_720, SH_720);
            q8_reg    <= recip_div(x8_reg, RECIP_40320, SH_40320);
            x7_reg    <= qmul(x6_reg, x_reg[3]);
            // stage 5: partial Taylor sums, mod 2^31 (final values stay in range)
            q7_reg <= recip_div(x7_reg, RECIP_5040, SH_5040);
            sp_reg <= {1'b0, x_reg[4]} - {1'b0, q3_reg[4]} + {1'b0, q5_reg};
            cv_reg <= ONE_Q - {2'b0, x2_reg[4][PH_BITS-1:1]} + {1'b0, q4_reg}
                      - {1'b0, q6_reg} + {1'b0, q8_reg};
            // stage 6
            s_reg <= s_next;
            c_reg <= c_next;
            // stage 7: rotate by minus the angle
            p_cdx_reg <= PROD_W'(c_reg) * PROD_W'(geo_reg[6].dx);
            p_sdy_reg <= PROD_W'(s_reg) * PROD_W'(geo_reg[6].dy);
            p_cdy_reg <= PROD_W'(c_reg) * PROD_W'(geo_reg[6].dy);
            p_sdx_reg <= PROD_W'(s_reg) * PROD_W'(geo_reg[6].dx);
            // stage 8: round to 1/2 pixel, floor shift
            rx_reg <= RX_W'(rx_sum >>> RND_SH);
            ry_reg <= RX_W'(ry_sum >>> RND_SH);
            // stage 9
            ex_reg <= ex_next;
            ey_reg <= ey_next;
            // stage 10: squares only matter when both excesses are under the radius
            near_reg <= (ex_reg < EX_W'(geo_reg[9].rad2)) && (ey_reg < EX_W'(geo_reg[9].rad2));
            e2x_reg  <= SQ_W'(ex_reg[RAD2_W-1:0]) * SQ_W'(ex_reg[RAD2_W-1:0]);
            e2y_reg  <= SQ_W'(ey_reg[RAD2_W-1:0]) * SQ_W'(ey_reg[RAD2_W-1:0]);
            r2_reg   <= SQ_W'(geo_reg[9].rad2) * SQ_W'(geo_reg[9].rad2);
            // stage 11
            hit_reg <= geo_reg[10].occupied && near_reg
                       && (({1'b0, e2x_reg} + {1'b0, e2y_reg}) < {1'b0, r2_reg});
        end
    end

endmodule

FILE: sv/cobc_checker.sv
// Port-level checks for the collision pipe, bound onto the top level.
module cobc_checker import cobc_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result_data
);

    logic [INFLIGHT_W-1:0] inflight_reg, inflight_next;
    logic                  in_acc, out_acc;

    assign in_acc  = item_valid && item_ready;
    assign out_acc = result_valid && result_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
            inflight_next = inflight_reg + INFLIGHT_W'(1);
        else if (out_acc && !in_acc)
            inflight_next = inflight_reg - INFLIGHT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result word changed or dropped while stalled");

    a_only_output_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("input held off without an output stall");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> inflight_reg != '0)
        else $error("result word with no word in flight");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= INFLIGHT_W'(PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

endmodule

bind circle_oriented_box_collision cobc_checker u_cobc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

FILE: sim/tb_circle_oriented_box_collision.sv
// Self-checking testbench for the circle vs oriented box collision pipe.
module tb_circle_oriented_box_collision import cobc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;

    typedef enum int {
        TAKE_ALL,
        TAKE_SOMETIMES,
        TAKE_RARELY
    } take_mode_t;

    logic clk;
    logic rst_n;

    cobc_item_if   item_ch ();
    cobc_result_if result_ch ();

    circle_oriented_box_collision DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    logic       expected_hits[$];
    int         mismatch_count = 0;
    int         idle_cycles = 0;
    int         burst_left = 0;
    int         stall_left = 0;
    take_mode_t take_mode = TAKE_ALL;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sin/cos over one octant, r in [0, 8192] of a 65536 turn, Q30 Taylor sums
    function automatic void taylor_octant(input longint unsigned r,
                                          output longint s, output longint c);
        longint unsigned x, x2, x3, x4, x5, x6, x7, x8, sin_q, cos_q;
        x  = r * 64'd102944;
        x2 = (x * x) >> 30;
        x3 = (x2 * x) >> 30;
        x4 = (x2 * x2) >> 30;
        x5 = (x4 * x) >> 30;
        x6 = (x4 * x2) >> 30;
        x7 = (x6 * x) >> 30;
        x8 = (x4 * x4) >> 30;
        sin_q = x - x3 / 64'd6 + x5 / 64'd120 - x7 / 64'd5040;
        cos_q = (64'd1 << 30) - x2 / 64'd2 + x4 / 64'd24 - x6 / 64'd720 + x8 / 64'd40320;
        s = longint'((sin_q + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS));
        c = longint'((cos_q + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS));
    endfunction

    function automatic void turn_sincos(input logic [ANGLE_BITS-1:0] ang,
                                        output longint s, output longint c);
        longint          s0, c0;
        longint unsigned r;
        r = longint'(ang[13:0]);
        if (r <= 64'd8192)
            taylor_octant(r, s0, c0);
        else
            taylor_octant(64'd16384 - r, c0, s0);
        unique case (quad_t'(ang[15:14]))
            QUAD_0:
            begin
                s = s0;
                c = c0;
            end
            QUAD_1:
            begin
                s = c0;
                c = -s0;
            end
            QUAD_2:
            begin
                s = -s0;
                c = -c0;
            end
            default:
            begin
                s = -c0;
                c = s0;
            end
        endcase
    endfunction

    function automatic longint outside_by(input longint v, input longint half);
        if (v > half)
            return v - half;
        if (v < -half)
            return -half - v;
        return 0;
    endfunction

    // working units after rotation are 1/2 px: half extents = full size field
    function automatic logic predict_hit(input item_t w);
        longint s, c, dx, dy, rx, ry, ex, ey, rad2, half_lsb;
        if (!w.occupied)
            return 1'b0;
        turn_sincos(w.box_angle, s, c);
        dx = longint'($signed(w.point_x)) - longint'($signed(w.box_x));
        dy = longint'($signed(w.point_y)) - longint'($signed(w.box_y));
        half_lsb = longint'(1) <<< (TRIG_FRAC_BITS - 2);
        rx = (c * dx + s * dy + half_lsb) >>> (TRIG_FRAC_BITS - 1);
        ry = (c * dy - s * dx + half_lsb) >>> (TRIG_FRAC_BITS - 1);
        ex = outside_by(rx, longint'(w.box_width));
        ey = outside_by(ry, longint'(w.box_height));
        rad2 = 2 * longint'(w.radius);
        if (ex < rad2 && ey < rad2)
            return (ex * ex < rad2 * rad2 - ey * ey);
        return 1'b0;
    endfunction

    function automatic item_t box_circle(input bit occ, input int bx, input int by,
                                         input int bw, input int bh, input int ang,
                                         input int px, input int py, input int rad);
        item_t w;
        w.occupied   = occ;
        w.box_x      = COORD_BITS'(bx);
        w.box_y      = COORD_BITS'(by);
        w.box_width  = (COORD_BITS-1)'(bw);
        w.box_height = (COORD_BITS-1)'(bh);
        w.box_angle  = ANGLE_BITS'(ang);
        w.point_x    = COORD_BITS'(px);
        w.point_y    = COORD_BITS'(py);
        w.radius     = (COORD_BITS-1)'(rad);
        return w;
    endfunction

    function automatic item_t random_item();
        return box_circle(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
    endfunction

    // sender runs in bursts; a burst starts after a random gap (often none)
    task automatic send_word(input item_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                item_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= w;
        do
            @(posedge clk);
        while (!item_ch.ready);
        burst_left--;
        expected_hits.push_back(predict_hit(w));
    endtask

    task automatic wait_results_done();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_hits.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        int angles[10] = '{0, 8192, 8193, 16384, 24576, 32768, 49152, 65535, 4000, 12000};
        take_mode = TAKE_ALL;
        // unoccupied never hits, even with the point at the box center
        send_word(box_circle(0, 0, 0, 160, 160, 0, 0, 0, 1000));
        send_word(box_circle(1, 0, 0, 160, 160, 0, 0, 0, 1000));
        // zero radius: strict compare, no hit even inside
        send_word(box_circle(1, 0, 0, 160, 160, 0, 0, 0, 0));
        // point-sized box
        send_word(box_circle(1, 100, -100, 0, 0, 0, 100, -100, 1));
        send_word(box_circle(1, 0, 0, 0, 0, 0, 16, 0, 8));
        send_word(box_circle(1, 0, 0, 0, 0, 0, 16, 0, 17));
        // far outside, largest offsets
        send_word(box_circle(1, -32768, -32768, 0, 0, 0, 32767, 32767, 32767));
        send_word(box_circle(1, 32767, 32767, 32767, 32767, 65535, -32768, -32768, 32767));
        send_word(box_circle(1, 0, 0, 32767, 32767, 65535, 32767, -32768, 32767));
        send_word(box_circle(1, 32767, -32768, 0, 32767, 0, 32767, -32768, 1));
        // thin box swept through the quadrants and octant boundaries
        foreach (angles[i])
            send_word(box_circle(1, 0, 0, 320, 0, angles[i], 0, 100, 60));
    endtask

    task automatic test_full_range();
        take_mode = TAKE_SOMETIMES;
        repeat (120)
            send_word(random_item());
    endtask

    // point placed around the box so hits and misses both show up
    task automatic test_near_box();
        item_t w;
        int    reach;
        for (int n = 0; n < 250; n++)
        begin
            if (n % 50 == 0)
                take_mode = take_mode_t'($urandom_range(0, 2));
            w = random_item();
            w.occupied = ($urandom_range(0, 7) != 0);
            w.box_x = COORD_BITS'(int'($urandom_range(0, 16383)) - 8192);
            w.box_y = COORD_BITS'(int'($urandom_range(0, 16383)) - 8192);
            if ($urandom_range(0, 9) != 0)
            begin
                w.box_width  = (COORD_BITS-1)'($urandom_range(0, 2047));
                w.box_height = (COORD_BITS-1)'($urandom_range(0, 2047));
                w.radius     = (COORD_BITS-1)'($urandom_range(0, 1023));
            end
            reach = int'(w.box_width > w.box_height ? w.box_width : w.box_height) / 2
                    + int'(w.radius) + 16;
            if (reach > 8000)
                reach = 8000;
            w.point_x = w.box_x + COORD_BITS'(int'($urandom_range(0, 2 * reach)) - reach);
            w.point_y = w.box_y + COORD_BITS'(int'($urandom_range(0, 2 * reach)) - reach);
            send_word(w);
        end
    endtask

    // groups of words, each followed by a full drain of the pipe
    task automatic test_drain_pause();
        take_mode = TAKE_RARELY;
        repeat (6)
        begin
            repeat ($urandom_range(1, 15))
                send_word(random_item());
            wait_results_done();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual hit=%0b",
                             $time, result_ch.data.hit);
                    mismatch_count++;
                end
                else if (result_ch.data.hit !== expected_hits[0])
                begin
                    $display("%0t: hit mismatch: expected %0b, actual %0b",
                             $time, expected_hits[0], result_ch.data.hit);
                    mismatch_count++;
                    void'(expected_hits.pop_front());
                end
                else
                    void'(expected_hits.pop_front());
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            unique case (take_mode)
                TAKE_SOMETIMES:
                    if ($urandom_range(0, 3) == 0)
                        stall_left <= $urandom_range(1, 4);
                TAKE_RARELY:
                    if ($urandom_range(0, 1) == 0)
                        stall_left <= $urandom_range(2, 20);
                default:
                    ;
            endcase
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_range();
        test_near_box();
        test_drain_pause();
        wait_results_done();
        repeat (PIPE_DEPTH + 8)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
